FILE: sv/tate_pkg.sv
// Shared types and constants for the tool alias table engine.
package tate_pkg;

	localparam int MAX_TOOLS_DEF = 16;
	localparam logic [4:0] MAG_SIZE_RESET = 5'd12;

	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_QUERY  = 2'd1;
	localparam logic [1:0] MODE_VERIFY = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ALIAS  = 2'd1;
	localparam logic [1:0] ST_BROKEN = 2'd2;
	localparam logic [1:0] ST_BAD    = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  entry_index;
		logic [4:0]  entry_position;
		logic [7:0]  entry_family;
		logic        entry_unusable;
		logic [15:0] entry_length;
		logic [7:0]  entry_size_class;
		logic [3:0]  entry_lube;
		logic [4:0]  query_tool;
		logic [15:0] use_mask;
	} tate_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  tool_out;
		logic [15:0] length_out;
		logic [7:0]  size_class_out;
		logic [3:0]  lube_out;
		logic [15:0] broken_mask;
	} tate_out_t;

	typedef struct packed {
		logic [4:0]  position;
		logic [7:0]  family;
		logic        unusable;
		logic [15:0] length;
		logic [7:0]  size_class;
		logic [3:0]  lube;
	} tate_entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_VSEL,
		S_SELF,
		S_SCAN,
		S_DONE
	} tate_state_t;

endpackage

FILE: sv/tool_alias_table_engine.sv
// Tool alias table engine: tool table memory, alias search sequencer and output register.
//
// The tool table sits in one synchronous memory with a single read port (one entry per
// cycle, data in the next cycle); per-entry valid bits cleared by reset make every entry
// read as zero until written, so no clearing pass is needed. A write item or a bad tool
// number goes straight to the completion state; a next-tool query reads its own entry
// and, for an unusable tool with a family, scans up to places entries for an alias,
// where places is min(magazine_size, MAX_TOOLS). A verify item visits each of the first
// min(16, places) tools in turn, and a used tool gets its own read and the alias scan.
// One item is in work at a time; a finished result waits in the output register while
// the next item is taken. The user must write magazine_size only while the block is
// idle; the block itself does not enforce this.
module tool_alias_table_engine import tate_pkg::*; #(
	parameter int MAX_TOOLS = MAX_TOOLS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  tate_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output tate_out_t out_data,
	input  logic      cfg_we,
	input  logic [4:0] cfg_wdata
);

	localparam int AW   = $clog2(MAX_TOOLS);
	localparam int NW   = $clog2(MAX_TOOLS + 1);
	localparam int VLIM = (MAX_TOOLS < 16) ? MAX_TOOLS : 16;
	localparam int VCW  = $clog2(VLIM + 1);

	tate_state_t state_q, state_d;

	logic [4:0]    mag_q;
	logic [NW-1:0] places;

	tate_entry_t mem [MAX_TOOLS];
	logic [MAX_TOOLS-1:0] vld_q;
	tate_entry_t rd_ent_s1;
	logic        rd_vld_s1;
	tate_entry_t ent;
	logic [AW-1:0] rd_addr;
	logic        mem_we;

	logic        pend_s1, pend_d;
	logic [1:0]  mode_q, mode_d;
	logic [15:0] use_q, use_d;
	logic [15:0] mask_q, mask_d;
	logic [7:0]  fam_q, fam_d;
	logic [VCW-1:0] i_q, i_d;
	logic [NW-1:0]  j_q, j_d;
	tate_out_t   res_q, res_d;
	tate_out_t   out_q;
	logic        out_valid_q;
	logic        load_out;
	logic        in_fire;
	logic        found;
	logic        fin_ok, fin_broken;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign ent       = rd_vld_s1 ? rd_ent_s1 : '0;
	assign found     = pend_s1 && (ent.family == fam_q) && !ent.unusable;

	always_comb begin
		if (int'(mag_q) >= MAX_TOOLS) begin
			places = NW'(MAX_TOOLS);
		end else begin
			places = NW'(mag_q);
		end
	end

	always_comb begin
		state_d    = state_q;
		res_d      = res_q;
		mode_d     = mode_q;
		use_d      = use_q;
		mask_d     = mask_q;
		fam_d      = fam_q;
		i_d        = i_q;
		j_d        = j_q;
		pend_d     = 1'b0;
		rd_addr    = AW'(j_q);
		mem_we     = 1'b0;
		load_out   = 1'b0;
		fin_ok     = 1'b0;
		fin_broken = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					mode_d = in_data.mode;
					use_d  = in_data.use_mask;
					mask_d = '0;
					i_d    = '0;
					res_d  = '0;
					case (in_data.mode)
						MODE_WRITE: begin
							mem_we  = (int'(in_data.entry_index) < MAX_TOOLS);
							state_d = S_DONE;
						end
						MODE_QUERY: begin
							res_d.tool_out = in_data.query_tool;
							if (in_data.query_tool == 5'd0 ||
							    int'(in_data.query_tool) > MAX_TOOLS) begin
								res_d.status = ST_BAD;
								state_d      = S_DONE;
							end else if (int'(in_data.query_tool) > int'(places)) begin
								res_d.status = ST_OK;
								state_d      = S_DONE;
							end else begin
								rd_addr = AW'(in_data.query_tool - 5'd1);
								state_d = S_SELF;
							end
						end
						MODE_VERIFY: begin
							state_d = S_VSEL;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_VSEL: begin
				if (int'(i_q) >= VLIM || int'(i_q) >= int'(places)) begin
					res_d.broken_mask = mask_q;
					state_d           = S_DONE;
				end else if (use_q[4'(i_q)]) begin
					rd_addr = AW'(i_q);
					state_d = S_SELF;
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			S_SELF: begin
				if (!ent.unusable) begin
					fin_ok = 1'b1;
				end else if (ent.family == 8'd0) begin
					fin_broken = 1'b1;
				end else begin
					fam_d   = ent.family;
					rd_addr = '0;
					j_d     = NW'(1);
					pend_d  = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (found) begin
					if (mode_q == MODE_QUERY && ent.position == 5'd0) begin
						fin_broken = 1'b1;
					end else begin
						if (mode_q == MODE_QUERY) begin
							res_d.status         = ST_ALIAS;
							res_d.tool_out       = ent.position;
							res_d.length_out     = ent.length;
							res_d.size_class_out = ent.size_class;
							res_d.lube_out       = ent.lube;
						end
						fin_ok = 1'b1;
					end
				end else if (!pend_s1) begin
					fin_broken = 1'b1;
				end else if (j_q < places) begin
					pend_d = 1'b1;
					j_d    = j_q + 1'b1;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin_broken) begin
			if (mode_q == MODE_QUERY) begin
				res_d.status = ST_BROKEN;
				state_d      = S_DONE;
			end else begin
				mask_d  = mask_q | (16'd1 << i_q);
				i_d     = i_q + 1'b1;
				state_d = S_VSEL;
			end
		end
		if (fin_ok) begin
			if (mode_q == MODE_QUERY) begin
				state_d = S_DONE;
			end else begin
				i_d     = i_q + 1'b1;
				state_d = S_VSEL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mag_q       <= MAG_SIZE_RESET;
			vld_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= pend_d;
			if (cfg_we) begin
				mag_q <= cfg_wdata;
			end
			if (mem_we) begin
				vld_q[AW'(in_data.entry_index)] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[AW'(in_data.entry_index)] <= '{
				position:   in_data.entry_position,
				family:     in_data.entry_family,
				unusable:   in_data.entry_unusable,
				length:     in_data.entry_length,
				size_class: in_data.entry_size_class,
				lube:       in_data.entry_lube
			};
		end
		rd_ent_s1 <= mem[rd_addr];
		rd_vld_s1 <= vld_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		res_q  <= res_d;
		mode_q <= mode_d;
		use_q  <= use_d;
		mask_q <= mask_d;
		fam_q  <= fam_d;
		i_q    <= i_d;
		j_q    <= j_d;
		if (load_out) begin
			out_q <= res_q;
		end
	end

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (state_q == S_DONE))
		else $error("result loaded outside completion state");

	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == S_SCAN))
		else $error("scan read pending outside scan state");

	a_alias_has_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_ALIAS) |-> (out_data.tool_out != 5'd0))
		else $error("alias reported with position zero");

	a_scan_one_query: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (mode_q == MODE_QUERY || mode_q == MODE_VERIFY))
		else $error("alias scan for a mode without lookups");

endmodule
